>>> hdl/epoch_seconds_to_calendar_date_defines.svh
// ============================================================================
// Assertion macros for the epoch seconds to calendar date block
// Concurrent checks that compile away when SYNTHESIS is defined.
// ============================================================================
`ifndef EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DATE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define ES2CD_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("es2cd: implication check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define ES2CD_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("es2cd: next-cycle check failed");

`else

`define ES2CD_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define ES2CD_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/es2cd_pkg.sv
// ============================================================================
// es2cd_pkg
// Types, constants and helper functions of the epoch to calendar converter.
// ============================================================================
package es2cd_pkg;

    localparam int unsigned SecsPerDayShift  = 48;
    localparam int unsigned SecsPerHourShift = 43;
    localparam int unsigned SecsPerMinShift  = 37;
    localparam int unsigned WeekShift        = 34;
    localparam int unsigned QuadShift        = 42;

    localparam logic [31:0] SecsPerDay   = 32'd86400;
    localparam logic [31:0] SecsPerHour  = 32'd3600;
    localparam logic [31:0] SecsPerMin   = 32'd60;
    localparam logic [31:0] DaysPerWeek  = 32'd7;
    localparam logic [31:0] DaysPerQuad  = 32'd1461;
    localparam logic [31:0] DaysTo1970   = 32'd25567;
    localparam logic [31:0] EpochWeekday = 32'd4;
    localparam logic [31:0] YearDays     = 32'd365;

    // Reciprocals rounded down, so the estimated quotient is never too large.
    localparam logic [31:0] RecipDay  = 32'((64'd1 << SecsPerDayShift) / 64'd86400);
    localparam logic [31:0] RecipHour = 32'((64'd1 << SecsPerHourShift) / 64'd3600);
    localparam logic [31:0] RecipMin  = 32'((64'd1 << SecsPerMinShift) / 64'd60);
    localparam logic [31:0] RecipWeek = 32'((64'd1 << WeekShift) / 64'd7);
    localparam logic [31:0] RecipQuad = 32'((64'd1 << QuadShift) / 64'd1461);

    localparam logic [3:0] LastMonth = 4'd11;
    localparam logic [3:0] February  = 4'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OFS_MUL,
        ST_OFS_ADD,
        ST_MUL_RECIP,
        ST_MUL_BACK,
        ST_SUB,
        ST_FIX,
        ST_YEAR,
        ST_MONTH
    } t_state;

    typedef enum logic [2:0] {
        DIV_DAY,
        DIV_HOUR,
        DIV_MIN,
        DIV_WEEK,
        DIV_QUAD
    } t_div;

    typedef struct packed {
        logic        mul_en;
        logic [31:0] mul_a;
        logic [31:0] mul_b;
        logic        sub;
        logic [31:0] add_a;
        logic [31:0] add_b;
    } t_alu_ctl;

    function automatic logic [31:0] div_const(input t_div d);
        logic [31:0] c;
        unique case (d)
            DIV_DAY:  c = SecsPerDay;
            DIV_HOUR: c = SecsPerHour;
            DIV_MIN:  c = SecsPerMin;
            DIV_WEEK: c = DaysPerWeek;
            DIV_QUAD: c = DaysPerQuad;
            default:  c = DaysPerQuad;
        endcase
        return c;
    endfunction

    function automatic logic [31:0] div_recip(input t_div d);
        logic [31:0] m;
        unique case (d)
            DIV_DAY:  m = RecipDay;
            DIV_HOUR: m = RecipHour;
            DIV_MIN:  m = RecipMin;
            DIV_WEEK: m = RecipWeek;
            DIV_QUAD: m = RecipQuad;
            default:  m = RecipQuad;
        endcase
        return m;
    endfunction

    // Leap test for a year counted from 1900. Within eight bits the only
    // century years are 1900, 2000 and 2100, and of these only 2000 leaps.
    function automatic logic is_leap(input logic [7:0] y);
        return ((y[1:0] == 2'b00) && (y != 8'd0) && (y != 8'd200));
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        case (m)
            February: len = leap ? 5'd29 : 5'd28;
            4'd3:     len = 5'd30;
            4'd5:     len = 5'd30;
            4'd8:     len = 5'd30;
            4'd10:    len = 5'd30;
            default:  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> hdl/es2cd_alu.sv
// ============================================================================
// es2cd_alu
// Shared arithmetic unit: a 32 by 32 multiplier with a registered product and
// a 32-bit adder/subtractor whose carry doubles as a greater-or-equal flag.
// ============================================================================
module es2cd_alu
    import es2cd_pkg::*;
(
    input  logic        i_clk,
    input  t_alu_ctl    i_ctl,
    output logic [63:0] o_prod,
    output logic [31:0] o_sum,
    output logic        o_ge
);

    logic [63:0] r_prod;
    logic [32:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= 64'(i_ctl.mul_a) * 64'(i_ctl.mul_b);
        end
    end

    // When subtracting, a carry out means the minuend was not smaller.
    assign n_sum = {1'b0, i_ctl.add_a}
                 + {1'b0, (i_ctl.sub ? ~i_ctl.add_b : i_ctl.add_b)}
                 + {32'd0, i_ctl.sub};

    assign o_prod = r_prod;
    assign o_sum  = n_sum[31:0];
    assign o_ge   = n_sum[32];

endmodule

>>> hdl/epoch_seconds_to_calendar_date.sv
// ============================================================================
// epoch_seconds_to_calendar_date
// Converts seconds since 1970-01-01 UTC, optionally shifted by a local offset
// in whole hours, into broken-down Gregorian date and time fields.
// ============================================================================
//
// Usage. A conversion transaction is accepted at a rising edge where start is
// high and busy is low; i_epoch_seconds and i_use_local are sampled there.
// busy then stays high until the result is out. The result appears on the o_
// ports for exactly one cycle, marked by o_result_strobe, and is taken at the
// edge that ends that cycle; the receiver cannot hold it off. A new transaction
// may be started in the strobe cycle itself.
//
// Sequence. In local mode ST_OFS_MUL and ST_OFS_ADD add the offset first. Then
// five divisions by a constant (seconds per day, hour and minute, then days per
// week and per four-year block) each run through ST_MUL_RECIP, ST_MUL_BACK,
// ST_SUB and ST_FIX. ST_YEAR then steps over the years after the four-year
// block (0 to 4) and ST_MONTH over the months (0 to 11), each walk ending in
// one finishing step. All steps share the single multiplier and adder, so a
// new transaction is accepted only once the last one has been strobed out.
//
// The offset register is written through i_cfg_we/i_cfg_wdata, by the user only
// while idle; the block itself does not enforce this. Synchronous reset returns
// the sequencer to idle, drops the strobe and clears the offset to zero.
// ============================================================================
`include "epoch_seconds_to_calendar_date_defines.svh"

module epoch_seconds_to_calendar_date
    import es2cd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic signed [4:0] i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic [31:0]       i_epoch_seconds,
    input  logic              i_use_local,
    output logic              o_result_strobe,
    output logic [5:0]        o_second,
    output logic [5:0]        o_minute,
    output logic [4:0]        o_hour,
    output logic [2:0]        o_weekday,
    output logic [7:0]        o_year_since_1900,
    output logic [8:0]        o_day_of_year,
    output logic [3:0]        o_month_index,
    output logic [4:0]        o_month_day
);

    // Sequencer and configuration state.
    t_state            r_state, n_state;
    t_div              r_div,   n_div;
    logic              r_strobe, n_strobe;
    logic signed [4:0] r_offset;

    // Working registers: r_x holds the value being divided or walked, r_q
    // the quotient of the division in progress.
    logic [31:0] r_x,    n_x;
    logic [31:0] r_q,    n_q;
    logic [15:0] r_days, n_days;

    // Result fields.
    logic [5:0] r_sec,  n_sec;
    logic [5:0] r_min,  n_min;
    logic [4:0] r_hour, n_hour;
    logic [2:0] r_wday, n_wday;
    logic [7:0] r_year, n_year;
    logic [8:0] r_yday, n_yday;
    logic [3:0] r_mon,  n_mon;
    logic [4:0] r_mday, n_mday;
    logic       r_leap, n_leap;

    // Shared unit.
    t_alu_ctl    alu_ctl;
    logic [63:0] alu_prod;
    logic [31:0] alu_sum;
    logic        alu_ge;

    // Helpers for the division steps.
    logic [31:0] q_est;
    logic [31:0] q_fin;
    logic [31:0] r_fin;
    logic [7:0]  quad_year;
    logic [1:0]  century_fix;
    logic [4:0]  cur_mlen;

    es2cd_alu u_alu (
        .i_clk  (i_clk),
        .i_ctl  (alu_ctl),
        .o_prod (alu_prod),
        .o_sum  (alu_sum),
        .o_ge   (alu_ge)
    );

    assign busy = (r_state != ST_IDLE);

    // The quotient estimate is the top of the product with the reciprocal;
    // the shift depends on which constant is being divided by.
    always_comb begin
        unique case (r_div)
            DIV_DAY:  q_est = 32'(alu_prod >> SecsPerDayShift);
            DIV_HOUR: q_est = 32'(alu_prod >> SecsPerHourShift);
            DIV_MIN:  q_est = 32'(alu_prod >> SecsPerMinShift);
            DIV_WEEK: q_est = 32'(alu_prod >> WeekShift);
            DIV_QUAD: q_est = 32'(alu_prod >> QuadShift);
            default:  q_est = 32'(alu_prod >> QuadShift);
        endcase
    end

    // The estimate is at most one short, so a single conditional subtract
    // of the divisor completes the division.
    assign q_fin = alu_ge ? (r_q + 32'd1) : r_q;
    assign r_fin = alu_ge ? alu_sum : r_x;

    // Day offset within a four-year block counted from 1900 is corrected
    // for the century years that do not leap: 1900 and 2100.
    assign quad_year   = {q_fin[5:0], 2'b00};
    assign century_fix = {1'b0, (quad_year != 8'd0)} + {1'b0, (quad_year >= 8'd201)};

    assign cur_mlen = month_len(r_mon, r_leap);

    always_comb begin
        n_state  = r_state;
        n_div    = r_div;
        n_strobe = 1'b0;
        n_x      = r_x;
        n_q      = r_q;
        n_days   = r_days;
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_wday   = r_wday;
        n_year   = r_year;
        n_yday   = r_yday;
        n_mon    = r_mon;
        n_mday   = r_mday;
        n_leap   = r_leap;
        alu_ctl  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_x     = i_epoch_seconds;
                    n_div   = DIV_DAY;
                    n_state = i_use_local ? ST_OFS_MUL : ST_MUL_RECIP;
                end
            end

            ST_OFS_MUL: begin
                // Offset in seconds; the low 32 bits of the product are the
                // two's complement value that the wrapping add needs.
                alu_ctl.mul_en = 1'b1;
                alu_ctl.mul_a  = {{27{r_offset[4]}}, r_offset};
                alu_ctl.mul_b  = SecsPerHour;
                n_state        = ST_OFS_ADD;
            end

            ST_OFS_ADD: begin
                alu_ctl.add_a = r_x;
                alu_ctl.add_b = alu_prod[31:0];
                n_x           = alu_sum;
                n_state       = ST_MUL_RECIP;
            end

            ST_MUL_RECIP: begin
                alu_ctl.mul_en = 1'b1;
                alu_ctl.mul_a  = r_x;
                alu_ctl.mul_b  = div_recip(r_div);
                n_state        = ST_MUL_BACK;
            end

            ST_MUL_BACK: begin
                alu_ctl.mul_en = 1'b1;
                alu_ctl.mul_a  = q_est;
                alu_ctl.mul_b  = div_const(r_div);
                n_q            = q_est;
                n_state        = ST_SUB;
            end

            ST_SUB: begin
                alu_ctl.sub   = 1'b1;
                alu_ctl.add_a = r_x;
                alu_ctl.add_b = alu_prod[31:0];
                n_x           = alu_sum;
                n_state       = ST_FIX;
            end

            ST_FIX: begin
                alu_ctl.sub   = 1'b1;
                alu_ctl.add_a = r_x;
                alu_ctl.add_b = div_const(r_div);
                n_state       = ST_MUL_RECIP;
                unique case (r_div)
                    DIV_DAY: begin
                        n_days = q_fin[15:0];
                        n_x    = r_fin;
                        n_div  = DIV_HOUR;
                    end
                    DIV_HOUR: begin
                        n_hour = q_fin[4:0];
                        n_x    = r_fin;
                        n_div  = DIV_MIN;
                    end
                    DIV_MIN: begin
                        n_min = q_fin[5:0];
                        n_sec = r_fin[5:0];
                        n_x   = {16'd0, r_days} + EpochWeekday;
                        n_div = DIV_WEEK;
                    end
                    DIV_WEEK: begin
                        n_wday = r_fin[2:0];
                        n_x    = {16'd0, r_days} + DaysTo1970;
                        n_div  = DIV_QUAD;
                    end
                    default: begin
                        n_year  = quad_year;
                        n_x     = r_fin + {30'd0, century_fix};
                        n_state = ST_YEAR;
                    end
                endcase
            end

            ST_YEAR: begin
                alu_ctl.sub   = 1'b1;
                alu_ctl.add_a = r_x;
                alu_ctl.add_b = YearDays + {31'd0, is_leap(r_year)};
                if (alu_ge) begin
                    n_x    = alu_sum;
                    n_year = r_year + 8'd1;
                end else begin
                    n_yday  = r_x[8:0];
                    n_leap  = is_leap(r_year);
                    n_mon   = '0;
                    n_state = ST_MONTH;
                end
            end

            ST_MONTH: begin
                alu_ctl.sub   = 1'b1;
                alu_ctl.add_a = r_x;
                alu_ctl.add_b = {27'd0, cur_mlen};
                if (alu_ge && (r_mon != LastMonth)) begin
                    n_x   = alu_sum;
                    n_mon = r_mon + 4'd1;
                end else begin
                    n_mday   = r_x[4:0] + 5'd1;
                    n_strobe = 1'b1;
                    n_state  = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_div    <= DIV_DAY;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_div    <= n_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else if (i_cfg_we) begin
            r_offset <= i_cfg_wdata;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_x    <= n_x;
        r_q    <= n_q;
        r_days <= n_days;
        r_sec  <= n_sec;
        r_min  <= n_min;
        r_hour <= n_hour;
        r_wday <= n_wday;
        r_year <= n_year;
        r_yday <= n_yday;
        r_mon  <= n_mon;
        r_mday <= n_mday;
        r_leap <= n_leap;
    end

    assign o_result_strobe   = r_strobe;
    assign o_second          = r_sec;
    assign o_minute          = r_min;
    assign o_hour            = r_hour;
    assign o_weekday         = r_wday;
    assign o_year_since_1900 = r_year;
    assign o_day_of_year     = r_yday;
    assign o_month_index     = r_mon;
    assign o_month_day       = r_mday;

    // The strobe is a single-cycle pulse, and it only ever appears when the
    // sequencer has already returned to idle.
    `ES2CD_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_result_strobe, !o_result_strobe)
    `ES2CD_ASSERT_IMP(a_strobe_idle, i_clk, i_rst_n, o_result_strobe, !busy)
    // An accepted transaction makes the block busy on the following cycle.
    `ES2CD_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // The reciprocal estimate leaves a remainder below twice the divisor.
    `ES2CD_ASSERT_IMP(a_fix_range, i_clk, i_rst_n, r_state == ST_FIX,
                      r_x < (div_const(r_div) << 1))
    // The month walk never runs past December.
    `ES2CD_ASSERT_IMP(a_month_range, i_clk, i_rst_n, r_state == ST_MONTH, r_mon <= LastMonth)

endmodule

>>> tb/tb.sv
// ============================================================================
// Testbench for epoch_seconds_to_calendar_date
// Drives conversion transactions through the start/busy handshake. It predicts
// each calendar date from the seconds count, the local-time flag and the
// offset register, and checks every strobed result field by field in order.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Random items in each offset phase, and the number of phases.
    localparam int unsigned ITEMS_PER_PHASE = 216;
    localparam int unsigned OFFSET_PHASES   = 8;

    // Cycles to watch for a stray strobe once nothing more is expected; this
    // covers a whole conversion at its slowest.
    localparam int unsigned DRAIN_CYCLES = 50;

    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned DAYS_PER_QUAD = 1461;
    localparam int unsigned DAYS_1900_TO_1970 = 25567;
    localparam int unsigned LAST_DAY_OF_RANGE = 49710;

    // One broken-down date, laid out in the order of the result ports.
    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
        logic [7:0] year_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month_index;
        logic [4:0] month_day;
    } t_cal_date;

    logic              i_clk;
    logic              i_rst_n         = 1'b0;
    logic              i_cfg_we        = 1'b0;
    logic signed [4:0] i_cfg_wdata     = '0;
    logic              start           = 1'b0;
    logic              busy;
    logic [31:0]       i_epoch_seconds = '0;
    logic              i_use_local     = 1'b0;
    logic              o_result_strobe;
    logic [5:0]        o_second;
    logic [5:0]        o_minute;
    logic [4:0]        o_hour;
    logic [2:0]        o_weekday;
    logic [7:0]        o_year_since_1900;
    logic [8:0]        o_day_of_year;
    logic [3:0]        o_month_index;
    logic [4:0]        o_month_day;

    // Gregorian leap rule for a year counted from 1900. The century rule is
    // shifted by 300 so that year 100 (2000) leaps and 0 and 200 do not.
    function automatic bit is_leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || ((y + 300) % 400 == 0);
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: holds the offset as last written, computes the date for
    // every accepted transaction and matches strobed results against the
    // oldest outstanding date.
    // ------------------------------------------------------------------------
    class date_scoreboard;
        logic signed [4:0] offset_hours;
        t_cal_date         pending_dates[$];
        int unsigned       errors;

        function new();
            offset_hours = '0;
            errors       = 0;
        endfunction

        function t_cal_date convert(logic [31:0] secs, logic use_local);
            int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            logic [31:0] t;
            logic [31:0] mins;
            logic [31:0] hours;
            logic [31:0] days;
            logic [31:0] year;
            logic [31:0] rem;
            logic [31:0] year_len;
            logic [31:0] month_len;
            logic [31:0] mon;
            bit          leap;
            t_cal_date   r;

            // The offset is sign-extended and the sum wraps at 32 bits.
            t = secs;
            if (use_local)
                t = secs + 32'(int'(offset_hours) * int'(SECS_PER_HOUR));

            r.second  = 6'(t % 60);
            mins      = t / 60;
            r.minute  = 6'(mins % 60);
            hours     = mins / 60;
            r.hour    = 5'(hours % 24);
            days      = hours / 24;
            r.weekday = 3'((days + 4) % 7);

            // Four-year blocks from 1900, corrected for the century years
            // that do not leap, then a short walk over the remaining years.
            days     = days + DAYS_1900_TO_1970;
            year     = (days / DAYS_PER_QUAD) * 4;
            rem      = days % DAYS_PER_QUAD + (year + 99) / 100 - (year + 299) / 400;
            year_len = is_leap_year(year) ? 366 : 365;
            while (rem >= year_len) begin
                rem      = rem - year_len;
                year     = year + 1;
                year_len = is_leap_year(year) ? 366 : 365;
            end
            leap              = is_leap_year(year);
            r.year_since_1900 = 8'(year);
            r.day_of_year     = 9'(rem);

            mon       = 0;
            month_len = month_days[0];
            while (rem >= month_len && mon < 11) begin
                rem       = rem - month_len;
                mon       = mon + 1;
                month_len = month_days[mon] + ((leap && mon == 1) ? 1 : 0);
            end
            r.month_index = 4'(mon);
            r.month_day   = 5'(rem + 1);
            return r;
        endfunction

        function void note_request(logic [31:0] secs, logic use_local);
            pending_dates.push_back(convert(secs, use_local));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_cal_date got);
            t_cal_date want;
            if (pending_dates.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual %p",
                         $time, got);
                errors++;
                return;
            end
            want = pending_dates.pop_front();
            compare_field("second", want.second, got.second);
            compare_field("minute", want.minute, got.minute);
            compare_field("hour", want.hour, got.hour);
            compare_field("weekday", want.weekday, got.weekday);
            compare_field("year_since_1900", want.year_since_1900, got.year_since_1900);
            compare_field("day_of_year", want.day_of_year, got.day_of_year);
            compare_field("month_index", want.month_index, got.month_index);
            compare_field("month_day", want.month_day, got.month_day);
        endfunction

        function int unsigned outstanding();
            return pending_dates.size();
        endfunction
    endclass

    date_scoreboard dates;

    epoch_seconds_to_calendar_date dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .start             (start),
        .busy              (busy),
        .i_epoch_seconds   (i_epoch_seconds),
        .i_use_local       (i_use_local),
        .o_result_strobe   (o_result_strobe),
        .o_second          (o_second),
        .o_minute          (o_minute),
        .o_hour            (o_hour),
        .o_weekday         (o_weekday),
        .o_year_since_1900 (o_year_since_1900),
        .o_day_of_year     (o_day_of_year),
        .o_month_index     (o_month_index),
        .o_month_day       (o_month_day)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Sends one conversion transaction. An optional gap with start low comes
    // first; start then stays high until the block takes the transaction. The
    // task returns in the time step of acceptance, so that a following call
    // with no gap keeps start high without lowering it in between.
    task automatic send_conversion(input logic [31:0] secs, input logic use_local,
                                   input bit back_to_back = 1'b0);
        int unsigned gap;
        gap = back_to_back ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start           <= 1'b1;
        i_epoch_seconds <= secs;
        i_use_local     <= use_local;
        do
            @(posedge i_clk);
        while (!(start && !busy));
        dates.note_request(secs, use_local);
    endtask

    // Holds the sender off until every outstanding date has been returned.
    // Only ever called straight after an acceptance, so the lowering of start
    // here never shares a time step with another assignment to it.
    task automatic wait_until_drained();
        start <= 1'b0;
        while (dates.outstanding() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_offset(input logic signed [4:0] hours);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= hours;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        dates.offset_hours = hours;
    endtask

    // Random seconds counts, weighted towards the places where the date
    // arithmetic is most likely to slip: midnight, new year and both ends of
    // the 32-bit range.
    function automatic logic [31:0] pick_epoch();
        int unsigned kind;
        int unsigned day;
        int unsigned y;
        int unsigned k;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            return $urandom();
        if (kind < 7) begin
            day = $urandom_range(0, LAST_DAY_OF_RANGE);
            return day * SECS_PER_DAY + $urandom_range(0, 10) - 5;
        end
        if (kind < 9) begin
            y   = $urandom_range(71, 206);
            day = 0;
            for (k = 70; k < y; k++)
                day += is_leap_year(k) ? 366 : 365;
            return day * SECS_PER_DAY + $urandom_range(0, 200000) - 100000;
        end
        if ($urandom_range(0, 1) != 0)
            return $urandom_range(0, 200000);
        return 32'hFFFF_FFFF - $urandom_range(0, 200000);
    endfunction

    // Every strobed result is taken at the edge that ends its cycle; the
    // values read here are those from before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe)
            dates.check_result({o_second, o_minute, o_hour, o_weekday, o_year_since_1900,
                                o_day_of_year, o_month_index, o_month_day});
    end

    initial begin
        logic signed [4:0] offset;
        dates = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed transactions at the reset offset of zero. Local mode with
        // a zero offset must match UTC.
        send_conversion(32'd0, 1'b0);
        send_conversion(32'd0, 1'b1);
        send_conversion(32'hFFFF_FFFF, 1'b0);            // last second of the range, 2106
        send_conversion(32'h7FFF_FFFF, 1'b0);            // the signed 32-bit rollover, 2038
        send_conversion(32'd68169600, 1'b0);             // 29 February 1972
        send_conversion(32'd94694399, 1'b1);             // last second of leap year 1972
        send_conversion(32'd946684799, 1'b1);            // last second of 1999
        send_conversion(32'd951782400, 1'b0);            // 29 February 2000, century leap year
        send_conversion(32'd978307199, 1'b0);            // day 365 of 2000
        send_conversion(32'd4107542399, 1'b0);           // 28 February 2100, no leap day
        send_conversion(32'd4107542400, 1'b0);           // 1 March 2100
        send_conversion(32'd4133980799, 1'b1);           // last second of 2100

        for (int phase = 0; phase < OFFSET_PHASES; phase++) begin
            if (phase != 0) begin
                // The offset only changes while the block is idle.
                wait_until_drained();
                case (phase)
                    1:       offset = 5'sd14;
                    2:       offset = -5'sd12;
                    3:       offset = 5'sd15;
                    4:       offset = -5'sd16;
                    default: offset = 5'($urandom_range(0, 31));
                endcase
                write_offset(offset);
                // Both ends of the range in local mode: a negative offset at
                // time zero wraps into 2106, a positive one at the top wraps
                // back into 1970.
                send_conversion(32'd0, 1'b1);
                send_conversion(32'hFFFF_FFFF, 1'b1);
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Every fourth run of 32 transactions goes back to back.
                send_conversion(pick_epoch(), 1'($urandom_range(0, 1)), (n / 32) % 4 == 0);
                if ($urandom_range(0, 99) == 0)
                    wait_until_drained();
            end
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (dates.errors == 0 && dates.outstanding() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Some 1750 transactions come to under 0.2 ms; this bound is ten times that.
    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
